[rtl/box_filter_downscaler_top_defines.svh]
// Assertion macros for the box filter downscaler checker.
// Needs clk and arst_n in the scope of use.
`ifndef BOX_FILTER_DOWNSCALER_TOP_DEFINES_SVH
`define BOX_FILTER_DOWNSCALER_TOP_DEFINES_SVH

// same-cycle implication
`define BFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box filter downscaler check failed");

// next-cycle implication
`define BFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box filter downscaler check failed");

`endif

[rtl/bfd_pkg.sv]
// Shared types and constants for the box filter downscaler.
// No dependencies.
`default_nettype none
package bfd_pkg;
	localparam int SUM_W = 40;
	localparam int CNT_W = 28;
	localparam int PIX_W = 8;
	localparam int Q_FRAC = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_SCALE_X = 3'd4,
		REG_SCALE_Y = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} bfd_acc_t;

	typedef struct packed {
		logic bank;
		logic [6:0] last_col;
		logic fend;
	} bfd_cmd_t;

	typedef struct packed {
		logic done;
		logic bank;
	} bfd_rel_t;
endpackage
`default_nettype wire

[rtl/bfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfd_ram #(
	parameter int W = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/bfd_cmdq.sv]
// Two-entry queue of row drain commands between front and back.
// Depends on bfd_pkg.
`default_nettype none
module bfd_cmdq
	import bfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bfd_cmd_t cmd_in,
	output logic full,
	input wire logic pop,
	output bfd_cmd_t cmd_out,
	output logic empty
);
	bfd_cmd_t ent_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign cmd_out = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && !empty) rd_q <= ~rd_q;
			case ({push && !full, pop && !empty})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/bfd_front.sv]
// Front part: configuration, pixel accumulation into the column banks, row-end decisions.
// Depends on bfd_pkg.
`default_nettype none
module bfd_front
	import bfd_pkg::*;
#(
	parameter int MAX_DST_W = 64,
	parameter int MAX_SRC_W = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_addr,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [PIX_W-1:0] pixel_in,
	output logic wr_en,
	output logic bank,
	output logic [(MAX_DST_W > 1 ? $clog2(MAX_DST_W) : 1)-1:0] addr,
	output bfd_acc_t wr_data,
	input wire bfd_acc_t rd_data,
	output logic [1:0][MAX_DST_W-1:0] col_valid,
	output logic cmd_push,
	output bfd_cmd_t cmd,
	input wire logic cmdq_full,
	input wire bfd_rel_t rel
);
	localparam int AW = MAX_DST_W > 1 ? $clog2(MAX_DST_W) : 1;
	localparam int CW = $clog2(MAX_SRC_W);
	localparam int PW = CW + 17;
	localparam logic [16:0] MAX_SW = 17'(MAX_SRC_W);
	localparam logic [6:0] MAX_DW = 7'(MAX_DST_W);

	typedef enum logic [2:0] {F_IDLE, F_IDX, F_RD, F_WR, F_END} fstate_t;

	logic [12:0] src_w_q;
	logic [15:0] src_h_q, dst_h_q;
	logic [6:0] dst_w_q;
	logic [16:0] scale_x_q, scale_y_q;

	fstate_t state_q;
	logic [CW-1:0] src_col_q;
	logic [15:0] src_row_q, dst_row_q;
	logic bank_q;
	logic [1:0] busy_q;
	logic [1:0][MAX_DST_W-1:0] valid_q;
	logic [PIX_W-1:0] pix_q;
	logic [PW-1:0] prod_q;
	logic [AW-1:0] dx_q;
	logic rdv_q;
	logic [33:0] ny_q;
	logic last_q;

	logic [16:0] sw_eff, kx_eff, ky_eff, next_row, dx_full;
	logic [15:0] sh_eff, dh_eff;
	logic [6:0] dw_eff, dw_m1;
	logic active, emit, hold, fend;

	always_comb begin
		if (src_w_q == '0) sw_eff = 17'd1;
		else if (17'(src_w_q) > MAX_SW) sw_eff = MAX_SW;
		else sw_eff = 17'(src_w_q);
		sh_eff = (src_h_q == '0) ? 16'd1 : src_h_q;
		dh_eff = (dst_h_q == '0) ? 16'd1 : dst_h_q;
		if (dst_w_q == '0) dw_eff = 7'd1;
		else if (dst_w_q > MAX_DW) dw_eff = MAX_DW;
		else dw_eff = dst_w_q;
		dw_m1 = dw_eff - 7'd1;
		kx_eff = (scale_x_q > ONE_Q16) ? ONE_Q16 : scale_x_q;
		ky_eff = (scale_y_q > ONE_Q16) ? ONE_Q16 : scale_y_q;
		active = dst_row_q < dh_eff;
		next_row = 17'(src_row_q) + 17'd1;
		dx_full = 17'(prod_q[PW-1:Q_FRAC]);
		emit = active && (last_q || ny_q >= {1'b0, 17'(dst_row_q) + 17'd1, 16'b0});
		hold = emit && (busy_q[~bank_q] || cmdq_full);
		fend = last_q || (17'(dst_row_q) + 17'd1 >= 17'(dh_eff));
	end

	assign in_stall = (state_q != F_IDLE);
	assign wr_en = (state_q == F_WR) && active;
	assign bank = bank_q;
	assign addr = dx_q;
	assign col_valid = valid_q;
	assign wr_data.sum = rdv_q ? rd_data.sum + SUM_W'(pix_q) : SUM_W'(pix_q);
	assign wr_data.cnt = rdv_q ? rd_data.cnt + CNT_W'(1) : CNT_W'(1);
	assign cmd_push = (state_q == F_END) && emit && !hold;
	assign cmd.bank = bank_q;
	assign cmd.last_col = dw_m1;
	assign cmd.fend = fend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 13'd1;
			src_h_q <= 16'd1;
			dst_w_q <= 7'd1;
			dst_h_q <= 16'd1;
			scale_x_q <= ONE_Q16;
			scale_y_q <= ONE_Q16;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SRC_WIDTH: src_w_q <= cfg_data[12:0];
				REG_SRC_HEIGHT: src_h_q <= cfg_data[15:0];
				REG_DST_WIDTH: dst_w_q <= cfg_data[6:0];
				REG_DST_HEIGHT: dst_h_q <= cfg_data[15:0];
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			pix_q <= pixel_in;
			prod_q <= PW'(src_col_q) * PW'(kx_eff);
		end
		if (state_q == F_IDX) begin
			dx_q <= (dx_full > 17'(dw_m1)) ? AW'(dw_m1) : AW'(dx_full);
		end
		if (state_q == F_RD) begin
			rdv_q <= valid_q[bank_q][dx_q];
		end
		if (state_q == F_WR) begin
			ny_q <= 34'(next_row) * 34'(ky_eff);
			last_q <= next_row >= 17'(sh_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			src_col_q <= '0;
			src_row_q <= '0;
			dst_row_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
			valid_q <= '0;
		end else begin
			if (rel.done) busy_q[rel.bank] <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_IDX;
				end
				F_IDX: state_q <= F_RD;
				F_RD: state_q <= F_WR;
				F_WR: begin
					if (active) valid_q[bank_q][dx_q] <= 1'b1;
					if (17'(src_col_q) + 17'd1 < sw_eff) begin
						src_col_q <= src_col_q + CW'(1);
						state_q <= F_IDLE;
					end else begin
						src_col_q <= '0;
						state_q <= F_END;
					end
				end
				F_END: begin
					if (!hold) begin
						if (emit) begin
							busy_q[bank_q] <= 1'b1;
							bank_q <= ~bank_q;
							valid_q[~bank_q] <= '0;
						end
						if (last_q) begin
							src_row_q <= '0;
							dst_row_q <= '0;
							if (!emit) valid_q[bank_q] <= '0;
						end else begin
							src_row_q <= next_row[15:0];
							if (emit) dst_row_q <= dst_row_q + 16'd1;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/bfd_back.sv]
// Back part: drains one column bank, divides sum by count per column, holds the output beat.
// Depends on bfd_pkg.
`default_nettype none
module bfd_back
	import bfd_pkg::*;
#(
	parameter int MAX_DST_W = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bfd_cmd_t cmd,
	input wire logic cmd_empty,
	output logic cmd_pop,
	output logic bank,
	output logic [(MAX_DST_W > 1 ? $clog2(MAX_DST_W) : 1)-1:0] addr,
	input wire bfd_acc_t rd_data,
	input wire logic [1:0][MAX_DST_W-1:0] col_valid,
	output bfd_rel_t rel,
	output logic out_valid,
	input wire logic out_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic row_end,
	output logic frame_end
);
	localparam int AW = MAX_DST_W > 1 ? $clog2(MAX_DST_W) : 1;

	typedef enum logic [2:0] {B_IDLE, B_RD, B_LD, B_DIV, B_OUT} bstate_t;

	bstate_t state_q;
	logic bank_q, fend_q, vld_q;
	logic [AW-1:0] col_q, last_q;
	logic [SUM_W-1:0] rem_q;
	logic [CNT_W-1:0] div_q;
	logic [2:0] step_q;
	logic [PIX_W-1:0] quo_q;
	logic out_valid_q, row_end_q, frame_end_q;
	logic [PIX_W-1:0] pix_out_q;

	logic [SUM_W-1:0] shifted;
	logic load, is_last;

	assign shifted = SUM_W'(div_q) << step_q;
	assign load = (state_q == B_OUT) && (!out_valid_q || !out_stall);
	assign is_last = (col_q == last_q);
	assign cmd_pop = (state_q == B_IDLE) && !cmd_empty;
	assign bank = bank_q;
	assign addr = col_q;
	assign rel.done = load && is_last;
	assign rel.bank = bank_q;
	assign out_valid = out_valid_q;
	assign pixel_out = pix_out_q;
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bank_q <= cmd.bank;
			last_q <= AW'(cmd.last_col);
			fend_q <= cmd.fend;
		end
		if (state_q == B_RD) vld_q <= col_valid[bank_q][col_q];
		if (state_q == B_LD) begin
			rem_q <= vld_q ? rd_data.sum : '0;
			div_q <= vld_q ? rd_data.cnt : '0;
			step_q <= 3'd7;
			quo_q <= '0;
		end
		if (state_q == B_DIV) begin
			if (rem_q >= shifted) begin
				rem_q <= rem_q - shifted;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 3'd1;
		end
		if (load) begin
			pix_out_q <= (div_q == '0) ? '0 : quo_q;
			row_end_q <= is_last;
			frame_end_q <= is_last && fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						col_q <= '0;
						state_q <= B_RD;
					end
				end
				B_RD: state_q <= B_LD;
				B_LD: state_q <= B_DIV;
				B_DIV: begin
					if (step_q == 3'd0) state_q <= B_OUT;
				end
				B_OUT: begin
					if (load) begin
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							col_q <= col_q + AW'(1);
							state_q <= B_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/box_filter_downscaler_top.sv]
// Top level of the box filter downscaler: front, command queue, back and two column banks.
// Depends on bfd_pkg, bfd_ram, bfd_cmdq, bfd_front, bfd_back.
//
// Takes 8-bit grey pixels in raster order and emits box averages of dst_width columns
// per output row. Each pixel passes through the front steps accept, column index multiply,
// bank read and bank update; the last pixel of a source row then also goes through the
// vertical decision. An emitted row is drained by the back column by column (bank
// read, load, 8 restoring divide steps, output register). Two column banks let the front
// accumulate the next row while the back drains; the front waits at a row end only when
// both banks hold rows still to be drained.
`default_nettype none
module box_filter_downscaler_top
	import bfd_pkg::*;
#(
	parameter int MAX_DST_W = 64,
	parameter int MAX_SRC_W = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_addr,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [PIX_W-1:0] pixel_in,
	output logic out_valid,
	input wire logic out_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic row_end,
	output logic frame_end
);
	localparam int AW = MAX_DST_W > 1 ? $clog2(MAX_DST_W) : 1;

	logic f_wr_en, f_bank, b_bank, cmd_push, cmdq_full, cmd_pop, cmd_empty;
	logic [AW-1:0] f_addr, b_addr;
	bfd_acc_t f_wr_data;
	bfd_acc_t rdata [2];
	logic [1:0][MAX_DST_W-1:0] col_valid;
	bfd_cmd_t cmd_in, cmd_out;
	bfd_rel_t rel;

	bfd_front #(.MAX_DST_W(MAX_DST_W), .MAX_SRC_W(MAX_SRC_W)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_data,
		.in_valid, .in_stall, .pixel_in,
		.wr_en(f_wr_en), .bank(f_bank), .addr(f_addr), .wr_data(f_wr_data),
		.rd_data(rdata[f_bank]), .col_valid,
		.cmd_push, .cmd(cmd_in), .cmdq_full, .rel
	);

	bfd_cmdq u_cmdq (
		.clk, .arst_n, .push(cmd_push), .cmd_in, .full(cmdq_full),
		.pop(cmd_pop), .cmd_out, .empty(cmd_empty)
	);

	bfd_back #(.MAX_DST_W(MAX_DST_W)) u_back (
		.clk, .arst_n, .cmd(cmd_out), .cmd_empty, .cmd_pop,
		.bank(b_bank), .addr(b_addr), .rd_data(rdata[b_bank]), .col_valid, .rel,
		.out_valid, .out_stall, .pixel_out, .row_end, .frame_end
	);

	for (genvar b = 0; b < 2; b++) begin : g_bank
		bfd_ram #(.W($bits(bfd_acc_t)), .DEPTH(MAX_DST_W)) u_ram (
			.clk,
			.we(f_wr_en && (f_bank == 1'(b))),
			.waddr(f_addr),
			.wdata(f_wr_data),
			.raddr((f_bank == 1'(b)) ? f_addr : b_addr),
			.rdata(rdata[b])
		);
	end
endmodule
`default_nettype wire

[rtl/bfd_checker.sv]
// Port-level checks for the box filter downscaler, bound to the top level.
// Depends on box_filter_downscaler_top_defines.svh.
`default_nettype none
`include "box_filter_downscaler_top_defines.svh"
module bfd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] pixel_out,
	input wire logic row_end,
	input wire logic frame_end
);
	`BFD_ASSERT_IMP(a_fend_on_row_end, out_valid && frame_end, row_end)
	`BFD_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
	`BFD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out))
	`BFD_ASSERT_NXT(a_flags_hold, out_valid && out_stall, $stable(row_end) && $stable(frame_end))
endmodule

bind box_filter_downscaler_top bfd_checker u_bfd_checker (.*);
`default_nettype wire

[tb/tb_box_filter_downscaler_top.sv]
// Testbench for box_filter_downscaler_top: drives pixel beats and register writes,
// predicts output beats with an in-bench box-filter model and checks them in order.
// Depends on bfd_pkg and the RTL of the downscaler.
`timescale 1ns / 100ps
`default_nettype none
module tb_box_filter_downscaler_top;
	import bfd_pkg::*;

	typedef struct packed {
		logic [7:0] pix;
		logic rend;
		logic fend;
	} avg_beat_t;

	class avg_scoreboard;
		logic [12:0] src_w;
		logic [15:0] src_h;
		logic [6:0] dst_w;
		logic [15:0] dst_h;
		logic [16:0] kx;
		logic [16:0] ky;
		logic [39:0] sums [64];
		logic [27:0] cnts [64];
		logic [11:0] col;
		logic [15:0] srow;
		logic [15:0] drow;
		avg_beat_t pending [$];
		int errors;

		function void clear_cols();
			for (int k = 0; k < 64; k++) begin
				sums[k] = '0;
				cnts[k] = '0;
			end
		endfunction

		function void reset_all();
			src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
			kx = ONE_Q16; ky = ONE_Q16;
			clear_cols();
			col = 0; srow = 0; drow = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [16:0] v);
			case (idx)
				REG_SRC_WIDTH: src_w = v[12:0];
				REG_SRC_HEIGHT: src_h = v[15:0];
				REG_DST_WIDTH: dst_w = v[6:0];
				REG_DST_HEIGHT: dst_h = v[15:0];
				REG_SCALE_X: kx = v;
				REG_SCALE_Y: ky = v;
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [7:0] p);
			longint unsigned sw, sh, dw, dh, sx, sy, dx, nxt, c;
			bit last, fe;
			avg_beat_t b;
			sw = (src_w == 0) ? 1 : (src_w > 4096 ? 4096 : src_w);
			sh = (src_h == 0) ? 1 : src_h;
			dw = (dst_w == 0) ? 1 : (dst_w > 64 ? 64 : dst_w);
			dh = (dst_h == 0) ? 1 : dst_h;
			sx = (kx > ONE_Q16) ? ONE_Q16 : kx;
			sy = (ky > ONE_Q16) ? ONE_Q16 : ky;
			if (drow < dh) begin
				dx = (longint'(col) * sx) >> 16;
				if (dx > dw - 1)
					dx = dw - 1;
				sums[dx] = sums[dx] + p;
				cnts[dx] = cnts[dx] + 1;
			end
			if (longint'(col) + 1 < sw) begin
				col = col + 1;
				return;
			end
			col = 0;
			nxt = longint'(srow) + 1;
			last = nxt >= sh;
			if (drow < dh && (last || nxt * sy >= ((longint'(drow) + 1) << 16))) begin
				fe = last || (longint'(drow) + 1 >= dh);
				for (int k = 0; k < dw; k++) begin
					c = cnts[k];
					b.pix = c ? 8'(longint'(sums[k]) / c) : 8'd0;
					b.rend = (k == dw - 1);
					b.fend = fe && (k == dw - 1);
					pending.push_back(b);
				end
				clear_cols();
				drow = drow + 1;
			end
			if (last) begin
				srow = 0;
				drow = 0;
				clear_cols();
			end else begin
				srow = nxt[15:0];
			end
		endfunction

		function void check_beat(avg_beat_t got);
			avg_beat_t exp_b;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %h", got));
				return;
			end
			exp_b = pending.pop_front();
			if (got.pix !== exp_b.pix)
				report_mismatch($sformatf("pixel_out %0d, want %0d", got.pix, exp_b.pix));
			if (got.rend !== exp_b.rend)
				report_mismatch($sformatf("row_end %0b, want %0b", got.rend, exp_b.rend));
			if (got.fend !== exp_b.fend)
				report_mismatch($sformatf("frame_end %0b, want %0b", got.fend, exp_b.fend));
		endfunction

		function void report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [PIX_W-1:0] pixel_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [PIX_W-1:0] pixel_out;
	logic row_end;
	logic frame_end;

	avg_scoreboard board;
	longint cycles = 0;
	bit hold_off = 0;

	always #10 clk = ~clk;

	box_filter_downscaler_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.pixel_in(pixel_in), .out_valid(out_valid), .out_stall(out_stall),
		.pixel_out(pixel_out), .row_end(row_end), .frame_end(frame_end)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_beat('{pixel_out, row_end, frame_end});
	end

	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
			end else begin
				g = gap_len();
				out_stall <= (g != 0);
				repeat (g > 0 ? g - 1 : 0) @(posedge clk);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= v[16:0];
		board.write_reg(idx, v[16:0]);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_frame(int unsigned sw, int unsigned sh, int unsigned dw,
			int unsigned dh, int unsigned kx, int unsigned ky);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_SCALE_X, kx);
		write_reg(REG_SCALE_Y, ky);
	endtask

	task automatic send_pixel(logic [7:0] p, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			@(posedge clk);
			in_valid <= 0;
			repeat (g - 1) @(posedge clk);
		end
		@(posedge clk);
		in_valid <= 1;
		pixel_in <= p;
		board.note_pixel(p);
		do @(posedge clk); while (in_stall);
		in_valid <= 0;
	endtask

	task automatic settle();
		@(posedge clk);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
	endtask

	task automatic rand_frame(int npix, bit gaps);
		int r;
		for (int i = 0; i < npix; i++) begin
			r = $urandom_range(0, 9);
			send_pixel(r == 0 ? 8'd0 : (r == 1 ? 8'd255 : 8'($urandom)), gaps);
		end
	endtask

	initial begin
		int sw, sh, dw, dh;
		board = new();
		board.reset_all();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		send_pixel(8'd0, 0);
		send_pixel(8'd255, 0);
		settle();
		set_frame(4, 2, 2, 1, 32768, 32768);
		rand_frame(8, 0);
		settle();
		set_frame(0, 0, 0, 0, 0, 0);
		rand_frame(3, 0);
		settle();
		set_frame(3, 3, 3, 3, 131071, 131071);
		send_pixel(8'd255, 0); send_pixel(8'd255, 0); send_pixel(8'd1, 0);
		rand_frame(6, 0);
		settle();
		set_frame(5, 3, 100, 2, 65536, 0);
		rand_frame(15, 0);
		settle();
		set_frame(8191, 2, 4, 1, 1, 65535);
		send_pixel(8'd255, 0);
		settle();
		set_frame(3, 6, 4, 2, 65536, 65536);
		rand_frame(18, 0);
		settle();

		set_frame(8, 6, 64, 6, 65536, 65536);
		hold_off = 1;
		fork
			rand_frame(48, 1);
			begin
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
		join
		settle();

		for (int f = 0; f < 16; f++) begin
			sw = $urandom_range(1, 8);
			sh = $urandom_range(1, 6);
			dw = $urandom_range(1, sw + 1);
			dh = $urandom_range(1, sh);
			set_frame(sw, sh, dw, dh, $urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
				: (dw * 65536) / sw, $urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
				: (dh * 65536) / sh);
			rand_frame(sw * sh + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0),
				f % 4 != 3);
			settle();
		end
		set_frame(64, 2, 64, 2, 65536, 65536);
		rand_frame(128, 1);
		settle();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

[box_filter_downscaler_top.f]
+incdir+rtl
rtl/bfd_pkg.sv
rtl/bfd_ram.sv
rtl/bfd_cmdq.sv
rtl/bfd_front.sv
rtl/bfd_back.sv
rtl/box_filter_downscaler_top.sv
rtl/bfd_checker.sv
tb/tb_box_filter_downscaler_top.sv
